### design/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

    // Largest payload length accepted in a frame; longer frames report a length fault.
    localparam int unsigned MAX_PAYLOAD = 255;

    // Result queue sizing. One transaction can produce up to two results.
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QUEUE_ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Start sequence tail byte.
    localparam logic [7:0] START_TAIL = 8'hFF;

    // Frame status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_START = 3'd1;
    localparam logic [2:0] ST_LEN_BAD  = 3'd2;
    localparam logic [2:0] ST_DATA_BAD = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_status;
        logic [2:0] status_code;
        logic       frame_end;
    } t_out_item;

    // Results produced by one accepted byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_result_pair;

    function automatic t_out_item make_status(input logic [2:0] code);
        t_out_item res;
        res.payload_byte = 8'd0;
        res.is_status    = 1'b1;
        res.status_code  = code;
        res.frame_end    = 1'b1;
        return res;
    endfunction

endpackage

`default_nettype wire

### design/checksummed_frame_deframer_core.sv
// Checksummed frame deframer.
// Input channel (i_valid / o_stall / i_item): one received byte per transaction,
// with buffer_end marking the last byte of a receive buffer. The block hunts
// for 00 00 FF, checks LEN against LCS, forwards each payload byte as it
// arrives and closes every frame with one status result (is_status = 1).
// Output channel (o_valid / i_stall / o_item): payload bytes and statuses in
// order. Payload goes out before the data checksum is known: drop the frame
// when its closing status is not ok.
// A result enters the result queue in the cycle after its byte is accepted, behind any older results.
// Throughput: one byte per cycle while o_stall is low. A byte yields at most two results (a payload
// byte followed by a truncation status); the four-entry result queue absorbs
// that, and o_stall rises only when fewer than two queue slots are free, which
// happens only while the receiver is stalling.
// Reset (i_rst_n low, synchronous): return to hunting, clear the checksum
// state and empty the result queue.
// Receiver stall: the head result holds steady; the queue fills and then
// backpressures the input side.
`default_nettype none

module checksummed_frame_deframer_core #(
    parameter int unsigned MAX_LEN = cfd_pkg::MAX_PAYLOAD
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire cfd_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output cfd_pkg::t_out_item      o_item
);
    import cfd_pkg::*;

    logic         accept;
    logic         queue_full;
    t_result_pair results;

    // Take a byte whenever the queue can absorb its worst-case burst.
    assign o_stall = queue_full;
    assign accept  = i_valid && !queue_full;

    cfd_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_results (results)
    );

    cfd_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_results (results),
        .o_full    (queue_full),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

`default_nettype wire

### design/cfd_parser.sv
`default_nettype none

module cfd_parser #(
    parameter int unsigned MAX_LEN = cfd_pkg::MAX_PAYLOAD
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire cfd_pkg::t_in_item    i_item,
    output cfd_pkg::t_result_pair     o_results
);
    import cfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_LCS,
        PH_DATA,
        PH_DCS
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [15:0]  r_recent, n_recent;
    logic [7:0]   r_len, n_len;
    logic [7:0]   r_left, n_left;
    logic [7:0]   r_sum, n_sum;
    logic         r_start_seen, n_start_seen;

    logic [7:0]   byte_in;
    logic [7:0]   len_check;
    logic [7:0]   data_check;
    logic [7:0]   left_dec;
    logic         closed;
    t_out_item    payload_res;
    t_result_pair res;

    always_comb begin
        byte_in      = i_item.rx_byte;
        len_check    = r_len + byte_in;
        data_check   = r_sum + byte_in;
        left_dec     = r_left - 8'd1;
        closed       = 1'b0;

        payload_res.payload_byte = byte_in;
        payload_res.is_status    = 1'b0;
        payload_res.status_code  = ST_OK;
        payload_res.frame_end    = 1'b0;

        res.count  = 2'd0;
        res.first  = '0;
        res.second = '0;

        n_phase      = r_phase;
        n_recent     = r_recent;
        n_len        = r_len;
        n_left       = r_left;
        n_sum        = r_sum;
        n_start_seen = r_start_seen;

        case (r_phase)
            PH_HUNT: begin
                if (r_recent == 16'h0000 && byte_in == START_TAIL) begin
                    n_phase      = PH_LEN;
                    n_start_seen = 1'b1;
                end else begin
                    n_recent = {r_recent[7:0], byte_in};
                end
            end
            PH_LEN: begin
                n_len   = byte_in;
                n_phase = PH_LCS;
            end
            PH_LCS: begin
                if (len_check != 8'd0 || r_len > 8'(MAX_LEN)) begin
                    res.first = make_status(ST_LEN_BAD);
                    res.count = 2'd1;
                    closed    = 1'b1;
                    n_phase   = PH_HUNT;
                    n_recent  = 16'hFFFF;
                    n_len     = 8'd0;
                    n_left    = 8'd0;
                    n_sum     = 8'd0;
                end else begin
                    n_left  = r_len;
                    n_sum   = 8'd0;
                    n_phase = (r_len == 8'd0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA: begin
                res.first = payload_res;
                res.count = 2'd1;
                n_sum     = data_check;
                n_left    = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = PH_DCS;
                end
            end
            PH_DCS: begin
                res.first = make_status((data_check == 8'd0) ? ST_OK : ST_DATA_BAD);
                res.count = 2'd1;
                closed    = 1'b1;
                n_phase   = PH_HUNT;
                n_recent  = 16'hFFFF;
                n_len     = 8'd0;
                n_left    = 8'd0;
                n_sum     = 8'd0;
            end
            default: begin
                n_phase  = PH_HUNT;
                n_recent = 16'hFFFF;
                n_len    = 8'd0;
                n_left   = 8'd0;
                n_sum    = 8'd0;
            end
        endcase

        // Buffer end: close out whatever is open or report that no start was found, then rearm the hunt.
        if (i_item.buffer_end) begin
            if (!closed) begin
                if (n_phase != PH_HUNT || !n_start_seen) begin
                    if (res.count == 2'd0) begin
                        res.first = make_status((n_phase != PH_HUNT) ? ST_TRUNC
                                                                     : ST_NO_START);
                        res.count = 2'd1;
                    end else begin
                        res.second = make_status((n_phase != PH_HUNT) ? ST_TRUNC
                                                                      : ST_NO_START);
                        res.count  = 2'd2;
                    end
                end
            end
            n_phase      = PH_HUNT;
            n_recent     = 16'hFFFF;
            n_len        = 8'd0;
            n_left       = 8'd0;
            n_sum        = 8'd0;
            n_start_seen = 1'b0;
        end

        if (!i_accept) begin
            res.count = 2'd0;
        end
        o_results = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_recent     <= 16'hFFFF;
            r_len        <= 8'd0;
            r_left       <= 8'd0;
            r_sum        <= 8'd0;
            r_start_seen <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_recent     <= n_recent;
            r_len        <= n_len;
            r_left       <= n_left;
            r_sum        <= n_sum;
            r_start_seen <= n_start_seen;
        end
    end

endmodule

`default_nettype wire

### design/cfd_out_queue.sv
`default_nettype none

module cfd_out_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cfd_pkg::t_result_pair i_results,
    output logic                       o_full,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output cfd_pkg::t_out_item         o_item
);
    import cfd_pkg::*;

    t_out_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_ADDR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_ADDR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0]    r_count, n_count;
    logic [QUEUE_ADDR_W-1:0]   wr_ptr_next;
    logic                      pop;

    assign pop         = o_valid && !i_stall;
    assign wr_ptr_next = r_wr_ptr + QUEUE_ADDR_W'(1);
    assign o_valid     = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];
    // Leave room for the largest burst one transaction can produce.
    assign o_full      = (r_count > QUEUE_CNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_ADDR_W'(i_results.count);
        n_rd_ptr = pop ? (r_rd_ptr + QUEUE_ADDR_W'(1)) : r_rd_ptr;
        n_count  = r_count + QUEUE_CNT_W'(i_results.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_results.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_results.first;
        end
        if (i_results.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_results.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### tb/checksummed_frame_deframer_core_test.sv
`timescale 1ns / 1ps

module checksummed_frame_deframer_core_test;
    import cfd_pkg::*;

    // Receive state of the deframer as the scoreboard tracks it.
    typedef enum logic [2:0] {
        SEEK_START,
        TAKE_LEN,
        TAKE_LCS,
        TAKE_PAYLOAD,
        TAKE_DCS
    } t_hunt_phase;

    // Ways a generated frame can be damaged on purpose.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_LCS,
        FRAME_BAD_DCS
    } t_frame_fault;

    // Track the deframer state per accepted byte, queue the results each byte
    // must produce, and match every delivered result against the oldest one.
    class deframer_scoreboard;
        t_hunt_phase phase;
        logic [15:0] hunt_window;
        logic [7:0]  frame_len;
        logic [7:0]  payload_left;
        logic [7:0]  payload_sum;
        logic        start_found;
        t_out_item   results_due[$];
        int          error_count;
        int          results_checked;
        int          status_seen[5];

        function new();
            restart_hunt();
            start_found = 1'b0;
            error_count = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void restart_hunt();
            phase        = SEEK_START;
            hunt_window  = 16'hFFFF;
            frame_len    = 8'd0;
            payload_left = 8'd0;
            payload_sum  = 8'd0;
        endfunction

        function t_out_item status_result(input logic [2:0] code);
            t_out_item r;
            r.payload_byte = 8'd0;
            r.is_status    = 1'b1;
            r.status_code  = code;
            r.frame_end    = 1'b1;
            return r;
        endfunction

        // Append one expected result behind those already due.
        function void queue_due(input t_out_item r);
            results_due.insert(results_due.size(), r);
        endfunction

        function int due_count();
            return results_due.size();
        endfunction

        function void absorb_byte(input t_in_item item);
            logic [7:0] b;
            logic [7:0] check_sum;
            logic       closed;
            t_out_item  r;
            b = item.rx_byte;
            closed = 1'b0;
            case (phase)
                SEEK_START: begin
                    if (hunt_window == 16'h0000 && b == START_TAIL) begin
                        phase = TAKE_LEN;
                        start_found = 1'b1;
                    end else begin
                        hunt_window = {hunt_window[7:0], b};
                    end
                end
                TAKE_LEN: begin
                    frame_len = b;
                    phase = TAKE_LCS;
                end
                TAKE_LCS: begin
                    check_sum = frame_len + b;
                    if (check_sum != 8'd0 || int'(frame_len) > int'(MAX_PAYLOAD)) begin
                        queue_due(status_result(ST_LEN_BAD));
                        restart_hunt();
                        closed = 1'b1;
                    end else begin
                        payload_left = frame_len;
                        payload_sum = 8'd0;
                        phase = (frame_len == 8'd0) ? TAKE_DCS : TAKE_PAYLOAD;
                    end
                end
                TAKE_PAYLOAD: begin
                    r.payload_byte = b;
                    r.is_status    = 1'b0;
                    r.status_code  = ST_OK;
                    r.frame_end    = 1'b0;
                    queue_due(r);
                    payload_sum = payload_sum + b;
                    payload_left = payload_left - 8'd1;
                    if (payload_left == 8'd0) phase = TAKE_DCS;
                end
                TAKE_DCS: begin
                    check_sum = payload_sum + b;
                    queue_due(status_result((check_sum == 8'd0) ? ST_OK : ST_DATA_BAD));
                    restart_hunt();
                    closed = 1'b1;
                end
                default: restart_hunt();
            endcase
            if (item.buffer_end) begin
                if (!closed) begin
                    if (phase != SEEK_START)
                        queue_due(status_result(ST_TRUNC));
                    else if (!start_found)
                        queue_due(status_result(ST_NO_START));
                end
                restart_hunt();
                start_found = 1'b0;
            end
        endfunction

        task report_mismatch(input string msg);
            error_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            results_checked++;
            if (got.is_status && got.status_code <= ST_TRUNC)
                status_seen[got.status_code]++;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf(
                    "result with nothing due: pay=%02h st=%0b code=%0d end=%0b",
                    got.payload_byte, got.is_status, got.status_code, got.frame_end));
            end else begin
                want = results_due.pop_front();
                if (got.payload_byte !== want.payload_byte || got.is_status !== want.is_status ||
                    got.status_code !== want.status_code || got.frame_end !== want.frame_end)
                    report_mismatch({
                        $sformatf("got pay=%02h st=%0b code=%0d end=%0b, ",
                            got.payload_byte, got.is_status, got.status_code,
                            got.frame_end),
                        $sformatf("want pay=%02h st=%0b code=%0d end=%0b",
                            want.payload_byte, want.is_status, want.status_code,
                            want.frame_end)});
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    t_in_item  byte_item = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    t_out_item res_item;

    deframer_scoreboard sb = new();

    // Bytes of the buffer about to be sent; the last one carries buffer_end.
    logic [7:0] rx_buf[$];

    int bytes_sent = 0;
    int buffers_sent = 0;
    int frames_built = 0;
    int holds_done = 0;

    // Receiver controls: a pending long hold-off, or a stretch with no stalls.
    int rx_hold_cycles = 0;
    bit rx_free = 1'b0;

    checksummed_frame_deframer_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (byte_valid),
        .o_stall (byte_stall),
        .i_item  (byte_item),
        .o_valid (res_valid),
        .i_stall (res_stall),
        .o_item  (res_item)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses results.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Bias noise toward 00 and FF so partial and overlapping start sequences show up.
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 8'h00;
        if (r < 40) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Keep most payloads short; a few are long, up to the full 255-byte length.
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 8'd0;
        if (r < 85) return 8'($urandom_range(1, 12));
        if (r < 98) return 8'($urandom_range(13, 60));
        return 8'($urandom_range(100, 255));
    endfunction

    // Append one byte to the end of the buffer under construction.
    function automatic void add_rx_byte(input logic [7:0] b);
        rx_buf.insert(rx_buf.size(), b);
    endfunction

    // Append one frame: optional preamble, 00 00 FF, LEN, LCS, payload, DCS,
    // optional postamble. Corrupt LCS or DCS when asked.
    function automatic void append_frame(input logic [7:0] len, input t_frame_fault fault);
        logic [7:0] lcs;
        logic [7:0] dcs;
        logic [7:0] sum;
        logic [7:0] pb;
        logic [7:0] skew;
        frames_built++;
        if ($urandom_range(0, 1)) add_rx_byte(8'h00);
        add_rx_byte(8'h00);
        add_rx_byte(8'h00);
        add_rx_byte(8'hFF);
        lcs = 8'd0 - len;
        if (fault == FRAME_BAD_LCS) begin
            skew = 8'($urandom_range(1, 255));
            lcs = lcs + skew;
        end
        add_rx_byte(len);
        add_rx_byte(lcs);
        sum = 8'd0;
        for (int i = 0; i < int'(len); i++) begin
            pb = ($urandom_range(0, 9) == 0) ? noise_byte() : 8'($urandom_range(0, 255));
            add_rx_byte(pb);
            sum = sum + pb;
        end
        dcs = 8'd0 - sum;
        if (fault == FRAME_BAD_DCS) begin
            skew = 8'($urandom_range(1, 255));
            dcs = dcs + skew;
        end
        add_rx_byte(dcs);
        if ($urandom_range(0, 1)) add_rx_byte(8'h00);
    endfunction

    // Offer one byte after an optional gap; hold it until the block takes it.
    // Called at a rising edge, returns at the edge of the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        t_in_item item;
        item.rx_byte = b;
        item.buffer_end = last;
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= item;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        sb.absorb_byte(item);
        bytes_sent++;
    endtask

    // Send the whole buffer, flagging its last byte; burst drops all gaps.
    task automatic send_buffer(input bit burst);
        buffers_sent++;
        foreach (rx_buf[i])
            send_byte(rx_buf[i], i == rx_buf.size() - 1, burst ? 0 : pick_gap());
    endtask

    // Pause the sender until every due result has come, then let the pipe settle.
    task automatic wait_all_results();
        byte_valid <= 1'b0;
        while (sb.due_count() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Build and send one random buffer: mostly well-formed frames with random
    // content, some damaged, some cut short, some plain noise.
    task automatic random_buffer(input bit burst);
        int kind;
        int fault;
        int cut_from;
        int cut_to;
        rx_buf.delete();
        cut_from = 0;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 8)) add_rx_byte(noise_byte());
        end else begin
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 3)) add_rx_byte(noise_byte());
                cut_from = rx_buf.size();
                fault = $urandom_range(0, 99);
                append_frame(pick_len(), (fault < 80) ? FRAME_GOOD :
                                         (fault < 90) ? FRAME_BAD_LCS : FRAME_BAD_DCS);
            end
            // Drop the tail of the last frame so the buffer ends mid-frame.
            if ($urandom_range(0, 99) < 15) begin
                cut_to = $urandom_range(cut_from + 1, rx_buf.size() - 1);
                while (rx_buf.size() > cut_to) void'(rx_buf.pop_back());
            end
        end
        send_buffer(burst);
    endtask

    // Receiver: random stall runs, a quiet mode with no stalls, and a long
    // hold-off counted here when requested. One assignment per edge.
    initial begin
        @(posedge clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                res_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                holds_done++;
            end else if (rx_free) begin
                res_stall <= 1'b0;
                @(posedge clk);
            end else begin
                res_stall <= ($urandom_range(0, 2) == 0);
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // Check every result transaction against the oldest one due.
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) sb.check_result(res_item);
    end

    initial begin
        int buf_idx;
        int waited;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: noise-only buffer, so no start is found.
        rx_buf = '{8'h12};
        send_buffer(1'b0);
        // Zero-length frame, DCS 00, buffer ends on the closing byte.
        rx_buf = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
        send_buffer(1'b0);
        // One payload byte FF with DCS 00: data checksum fault.
        rx_buf = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'h00};
        send_buffer(1'b0);
        // LEN 03 with LCS 00: length fault on the last byte of the buffer.
        rx_buf = '{8'h00, 8'h00, 8'hFF, 8'h03, 8'h00};
        send_buffer(1'b0);
        // Buffer ends on a payload byte: payload 00 then truncation.
        rx_buf = '{8'h00, 8'h00, 8'hFF, 8'h02, 8'hFE, 8'h00};
        send_buffer(1'b0);
        wait_all_results();

        // Random buffers until about 730 bytes have gone in.
        buf_idx = 0;
        while (bytes_sent < 730) begin
            buf_idx++;
            if (buf_idx == 12 || buf_idx == 60) begin
                // Hold the receiver off while a long frame streams in back to
                // back, so the queue fills and the block stalls its input.
                rx_free = 1'b0;
                rx_hold_cycles = 400;
                rx_buf.delete();
                append_frame(8'd40, FRAME_GOOD);
                send_buffer(1'b1);
                wait_all_results();
            end
            // Every ninth buffer runs with no gaps on either side.
            rx_free = (buf_idx % 9 == 4);
            random_buffer(buf_idx % 9 == 4);
            if (buf_idx % 20 == 0) wait_all_results();
        end
        rx_free = 1'b0;

        // Drain: wait for the last results, with a limit, then settle.
        byte_valid <= 1'b0;
        waited = 0;
        while (sb.due_count() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.due_count() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.due_count()));

        $display("Covered %0d bytes, %0d buffers, %0d frames, %0d long hold-offs, %0d results",
            bytes_sent, buffers_sent, frames_built, holds_done, sb.results_checked);
        $display("Statuses: ok %0d, no start %0d, len fault %0d, data fault %0d, truncated %0d",
            sb.status_seen[ST_OK], sb.status_seen[ST_NO_START], sb.status_seen[ST_LEN_BAD],
            sb.status_seen[ST_DATA_BAD], sb.status_seen[ST_TRUNC]);
        if (sb.error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
